/* rtl/cfk_pkg.sv */
// ----------------------------------------------------------------------------
// cfk_pkg: shared types and helpers for the friction kinematic step
// Sequencer states, serial arithmetic unit codes and fixed-point helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cfk_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_MASS    = 3'd0;
  localparam logic [2:0] REG_GRAVITY = 3'd1;
  localparam logic [2:0] REG_STATIC  = 3'd2;
  localparam logic [2:0] REG_KINETIC = 3'd3;
  localparam logic [2:0] REG_BASE_X  = 3'd4;
  localparam logic [2:0] REG_BASE_Y  = 3'd5;

  // Reset values of the configuration registers
  localparam logic [31:0] MASS_RESET    = 32'd65536;
  localparam logic [31:0] GRAVITY_RESET = 32'd642253;
  localparam logic [15:0] STATIC_RESET  = 16'd2048;
  localparam logic [15:0] KINETIC_RESET = 16'd1229;

  // Input item kinds
  localparam logic FUNC_FORCE = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  // Serial arithmetic unit operations
  typedef enum logic [1:0] {
    ALU_MUL,
    ALU_DIV,
    ALU_SQRT
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_sts_t;

  // Tick sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_AK,
    ST_DV,
    ST_NQ,
    ST_FS,
    ST_SQ,
    ST_AMT2,
    ST_ROOT,
    ST_SCALE,
    ST_DIVL,
    ST_QM,
    ST_DT2,
    ST_PV,
    ST_PA,
    ST_VA,
    ST_OUT
  } st_t;

  // Magnitude of a signed 32-bit value as an unsigned 32-bit value
  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    logic signed [31:0] n;
    n = -v;
    return v[31] ? 32'(n) : 32'(v);
  endfunction

  // Saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [31:0] r;
    if (v > 50'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -50'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

/* rtl/coulomb_friction_kinematic_step.sv */
// ----------------------------------------------------------------------------
// coulomb_friction_kinematic_step: 2D point mass step with Coulomb friction
// Accumulates force words; on a tick word applies friction if friction_on is set, integrates
// position and velocity in signed Q16.16 and emits one result word.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in_     | input     | in_tvalid/in_tready  | in_tdata, in_tuser (func)
//  out_    | output    | out_tvalid/out_tready| out_tdata
//  cfg_    | input     | cfg_we               | cfg_index, cfg_wdata
//
//  A tick word runs multiplies and divides, with friction also a root, on the
//  serial arithmetic unit, one bit per cycle; no new word is taken until the
//  tick ends.
//  Synchronous reset clears position, velocity and accumulated force.
//  A result waiting on out_tready holds the next tick at its final step only.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module coulomb_friction_kinematic_step (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [31:0] force_x, [63:32] force_y, [79:64] delta_time, [80] friction_on
  input  logic [87:0]  in_tdata,
  // [0] func
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] position_x, [63:32] position_y, [95:64] velocity_x,
  // [127:96] velocity_y, [128] moving
  output logic [135:0] out_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_wdata
);

  localparam logic [47:0] NQ_LIMIT = 48'h1000_0000_0000;  // 2^44
  localparam logic [63:0] FS_CAP   = 64'h100_0000_0000;   // 2^40
  localparam logic [48:0] Q_SAT    = 49'h100_0000_0000;   // 2^40

  cfk_pkg::st_t state_r, state_nxt;

  // Configuration
  logic [31:0]        mass_r, grav_r;
  logic [15:0]        mus_r, muk_r;
  logic signed [31:0] basex_r, basey_r;

  // Body state
  logic signed [31:0] netx_r, nety_r, posx_r, posy_r, velx_r, vely_r;
  logic               hasf_r, moving_r;

  // Tick work registers
  logic [15:0]        dt_r;
  logic               fric_r, kpath_r, axis_r, issued_r;
  logic [47:0]        amt_r;
  logic [63:0]        sq_r, tmp_r;
  logic [31:0]        len_r, dt2_r;
  logic signed [31:0] ax_r, ay_r;
  logic signed [35:0] dp_r;

  // Output register
  logic               out_valid_r;
  logic [135:0]       out_data_r;

  // Arithmetic unit
  cfk_pkg::alu_req_t  alu_req;
  cfk_pkg::alu_sts_t  alu_sts;
  logic [63:0]        alu_a, alu_res;
  logic [31:0]        alu_b;
  logic               op_state;

  logic               in_acc, out_free, qm_bypass, step_done;
  logic signed [31:0] vec_cur, vel_cur, acc_cur, net_cur, dir_new;
  logic signed [32:0] fx_sum, fy_sum;
  logic [63:0]        nq, fs;
  logic [48:0]        q_mag;
  logic signed [49:0] q_s, base_s;
  logic [32:0]        r_v;
  logic [30:0]        r_a;

  assign in_tready = (state_r == cfk_pkg::ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign vec_cur = kpath_r ? (axis_r ? vely_r : velx_r) : (axis_r ? nety_r : netx_r);
  assign vel_cur = axis_r ? vely_r : velx_r;
  assign acc_cur = axis_r ? ay_r : ax_r;
  assign net_cur = axis_r ? nety_r : netx_r;

  assign qm_bypass = (net_cur == 32'sd0) || (mass_r == 32'd0);
  assign step_done = alu_sts.done || ((state_r == cfk_pkg::ST_QM) && qm_bypass);

  assign fx_sum = 33'(netx_r) + 33'($signed(in_tdata[31:0]));
  assign fy_sum = 33'(nety_r) + 33'($signed(in_tdata[63:32]));

  assign nq = alu_res >> 16;
  assign fs = alu_res >> 12;
  assign dir_new = (vec_cur > 32'sd0) ? vec_cur - $signed(alu_res[31:0])
                                      : vec_cur + $signed(alu_res[31:0]);

  // Force over mass, then add the base acceleration and saturate
  assign q_mag  = qm_bypass ? ((net_cur == 32'sd0) ? 49'd0 : Q_SAT) : alu_res[48:0];
  assign q_s    = net_cur[31] ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
  assign base_s = hasf_r ? (axis_r ? 50'(basey_r) : 50'(basex_r)) : 50'sd0;

  assign r_v = alu_res[48:16];
  assign r_a = alu_res[63:33];

  cfk_serial_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (alu_req),
    .a_i    (alu_a),
    .b_i    (alu_b),
    .result (alu_res),
    .sts    (alu_sts)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cfk_pkg::ST_IDLE: begin
        if (in_acc && (in_tuser == cfk_pkg::FUNC_TICK)) begin
          state_nxt = cfk_pkg::ST_DECIDE;
        end
      end
      cfk_pkg::ST_DECIDE: begin
        if (!fric_r) begin
          state_nxt = cfk_pkg::ST_QM;
        end else if (moving_r) begin
          state_nxt = cfk_pkg::ST_AK;
        end else begin
          state_nxt = cfk_pkg::ST_NQ;
        end
      end
      cfk_pkg::ST_AK: if (step_done) state_nxt = cfk_pkg::ST_DV;
      cfk_pkg::ST_DV: if (step_done) state_nxt = cfk_pkg::ST_SQ;
      cfk_pkg::ST_NQ: begin
        if (step_done) begin
          if (mus_r == 16'd0 || nq > 64'(NQ_LIMIT)) begin
            state_nxt = cfk_pkg::ST_SQ;
          end else begin
            state_nxt = cfk_pkg::ST_FS;
          end
        end
      end
      cfk_pkg::ST_FS: if (step_done) state_nxt = cfk_pkg::ST_SQ;
      cfk_pkg::ST_SQ: begin
        if (step_done && axis_r) begin
          state_nxt = (amt_r[47:32] != 16'd0) ? cfk_pkg::ST_QM : cfk_pkg::ST_AMT2;
        end
      end
      cfk_pkg::ST_AMT2: begin
        if (step_done) begin
          state_nxt = (alu_res >= sq_r) ? cfk_pkg::ST_QM : cfk_pkg::ST_ROOT;
        end
      end
      cfk_pkg::ST_ROOT:  if (step_done) state_nxt = cfk_pkg::ST_SCALE;
      cfk_pkg::ST_SCALE: if (step_done) state_nxt = cfk_pkg::ST_DIVL;
      cfk_pkg::ST_DIVL: begin
        if (step_done) state_nxt = axis_r ? cfk_pkg::ST_QM : cfk_pkg::ST_SCALE;
      end
      cfk_pkg::ST_QM: begin
        if (step_done && axis_r) state_nxt = cfk_pkg::ST_DT2;
      end
      cfk_pkg::ST_DT2: if (step_done) state_nxt = cfk_pkg::ST_PV;
      cfk_pkg::ST_PV:  if (step_done) state_nxt = cfk_pkg::ST_PA;
      cfk_pkg::ST_PA:  if (step_done) state_nxt = cfk_pkg::ST_VA;
      cfk_pkg::ST_VA: begin
        if (step_done) state_nxt = axis_r ? cfk_pkg::ST_OUT : cfk_pkg::ST_PV;
      end
      cfk_pkg::ST_OUT: if (out_free) state_nxt = cfk_pkg::ST_IDLE;
      default: state_nxt = cfk_pkg::ST_IDLE;
    endcase
  end

  // Arithmetic unit requests
  always_comb begin
    op_state   = 1'b1;
    alu_req.op = cfk_pkg::ALU_MUL;
    alu_a      = 64'd0;
    alu_b      = 32'd0;
    case (state_r)
      cfk_pkg::ST_AK: begin
        alu_a = 64'(grav_r);
        alu_b = 32'(muk_r);
      end
      cfk_pkg::ST_DV: begin
        alu_a = 64'(amt_r);
        alu_b = 32'(dt_r);
      end
      cfk_pkg::ST_NQ: begin
        alu_a = 64'(grav_r);
        alu_b = mass_r;
      end
      cfk_pkg::ST_FS: begin
        alu_a = 64'(amt_r);
        alu_b = 32'(mus_r);
      end
      cfk_pkg::ST_SQ: begin
        alu_a = 64'(cfk_pkg::mag32(vec_cur));
        alu_b = cfk_pkg::mag32(vec_cur);
      end
      cfk_pkg::ST_AMT2: begin
        alu_a = 64'(amt_r[31:0]);
        alu_b = amt_r[31:0];
      end
      cfk_pkg::ST_ROOT: begin
        alu_req.op = cfk_pkg::ALU_SQRT;
        alu_a      = sq_r;
      end
      cfk_pkg::ST_SCALE: begin
        alu_a = 64'(cfk_pkg::mag32(vec_cur));
        alu_b = amt_r[31:0];
      end
      cfk_pkg::ST_DIVL: begin
        alu_req.op = cfk_pkg::ALU_DIV;
        alu_a      = tmp_r;
        alu_b      = len_r;
      end
      cfk_pkg::ST_QM: begin
        alu_req.op = cfk_pkg::ALU_DIV;
        alu_a      = {16'd0, cfk_pkg::mag32(net_cur), 16'd0};
        alu_b      = mass_r;
      end
      cfk_pkg::ST_DT2: begin
        alu_a = 64'(dt_r);
        alu_b = 32'(dt_r);
      end
      cfk_pkg::ST_PV: begin
        alu_a = 64'(cfk_pkg::mag32(vel_cur));
        alu_b = 32'(dt_r);
      end
      cfk_pkg::ST_PA: begin
        alu_a = 64'(cfk_pkg::mag32(acc_cur));
        alu_b = dt2_r;
      end
      cfk_pkg::ST_VA: begin
        alu_a = 64'(cfk_pkg::mag32(acc_cur));
        alu_b = 32'(dt_r);
      end
      default: op_state = 1'b0;
    endcase
    alu_req.start = op_state && !issued_r &&
                    !((state_r == cfk_pkg::ST_QM) && qm_bypass);
  end

  // Control, configuration and body state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cfk_pkg::ST_IDLE;
      issued_r    <= 1'b0;
      axis_r      <= 1'b0;
      out_valid_r <= 1'b0;
      mass_r      <= cfk_pkg::MASS_RESET;
      grav_r      <= cfk_pkg::GRAVITY_RESET;
      mus_r       <= cfk_pkg::STATIC_RESET;
      muk_r       <= cfk_pkg::KINETIC_RESET;
      basex_r     <= 32'sd0;
      basey_r     <= 32'sd0;
      netx_r      <= 32'sd0;
      nety_r      <= 32'sd0;
      hasf_r      <= 1'b0;
      posx_r      <= 32'sd0;
      posy_r      <= 32'sd0;
      velx_r      <= 32'sd0;
      vely_r      <= 32'sd0;
      moving_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // Track the outstanding unit request
      if (alu_req.start) begin
        issued_r <= 1'b1;
      end else if (alu_sts.done) begin
        issued_r <= 1'b0;
      end

      // Alternate axes inside the per-axis loops
      if (state_r == cfk_pkg::ST_DECIDE) begin
        axis_r <= 1'b0;
      end else if (step_done && (state_r == cfk_pkg::ST_SQ || state_r == cfk_pkg::ST_DIVL ||
                                 state_r == cfk_pkg::ST_QM || state_r == cfk_pkg::ST_VA)) begin
        axis_r <= !axis_r;
      end

      // Load the result word or release it once taken
      if ((state_r == cfk_pkg::ST_OUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end

      // Write configuration
      if (cfg_we) begin
        case (cfg_index)
          cfk_pkg::REG_MASS:    mass_r  <= cfg_wdata;
          cfk_pkg::REG_GRAVITY: grav_r  <= cfg_wdata;
          cfk_pkg::REG_STATIC:  mus_r   <= cfg_wdata[15:0];
          cfk_pkg::REG_KINETIC: muk_r   <= cfg_wdata[15:0];
          cfk_pkg::REG_BASE_X:  basex_r <= $signed(cfg_wdata);
          cfk_pkg::REG_BASE_Y:  basey_r <= $signed(cfg_wdata);
          default: begin
            mass_r <= mass_r;
          end
        endcase
      end

      case (state_r)
        cfk_pkg::ST_IDLE: begin
          if (in_acc) begin
            if (in_tuser == cfk_pkg::FUNC_FORCE) begin
              netx_r <= cfk_pkg::sat32(50'(fx_sum));
              nety_r <= cfk_pkg::sat32(50'(fy_sum));
              hasf_r <= 1'b1;
            end else begin
              moving_r <= (velx_r != 32'sd0) || (vely_r != 32'sd0);
            end
          end
        end
        cfk_pkg::ST_SQ, cfk_pkg::ST_AMT2: begin
          // Friction consumes the whole vector: drop it
          if (step_done && state_nxt == cfk_pkg::ST_QM) begin
            if (kpath_r) begin
              velx_r <= 32'sd0;
              vely_r <= 32'sd0;
            end else begin
              netx_r <= 32'sd0;
              nety_r <= 32'sd0;
            end
          end
        end
        cfk_pkg::ST_DIVL: begin
          // Shorten one component toward zero
          if (step_done) begin
            case ({kpath_r, axis_r})
              2'b00:   netx_r <= dir_new;
              2'b01:   nety_r <= dir_new;
              2'b10:   velx_r <= dir_new;
              default: vely_r <= dir_new;
            endcase
          end
        end
        cfk_pkg::ST_VA: begin
          if (step_done) begin
            if (axis_r) begin
              posy_r <= cfk_pkg::sat32(50'(posy_r) + 50'(dp_r));
              vely_r <= cfk_pkg::sat32(50'(vely_r) +
                        (ay_r[31] ? -$signed(50'(r_v)) : $signed(50'(r_v))));
            end else begin
              posx_r <= cfk_pkg::sat32(50'(posx_r) + 50'(dp_r));
              velx_r <= cfk_pkg::sat32(50'(velx_r) +
                        (ax_r[31] ? -$signed(50'(r_v)) : $signed(50'(r_v))));
            end
          end
        end
        cfk_pkg::ST_OUT: begin
          if (out_free) begin
            netx_r      <= 32'sd0;
            nety_r      <= 32'sd0;
            hasf_r      <= 1'b0;
          end
        end
        default: begin
          hasf_r <= hasf_r;
        end
      endcase
    end
  end

  // Tick work registers and result word
  always_ff @(posedge clk) begin
    case (state_r)
      cfk_pkg::ST_IDLE: begin
        if (in_acc) begin
          dt_r   <= in_tdata[79:64];
          fric_r <= in_tdata[80];
        end
      end
      cfk_pkg::ST_DECIDE: kpath_r <= moving_r;
      cfk_pkg::ST_AK: if (step_done) amt_r <= 48'(alu_res >> 12);
      cfk_pkg::ST_DV: if (step_done) amt_r <= 48'(alu_res >> 16);
      cfk_pkg::ST_NQ: begin
        if (step_done) begin
          if (mus_r == 16'd0) begin
            amt_r <= 48'd0;
          end else if (nq > 64'(NQ_LIMIT)) begin
            amt_r <= 48'(FS_CAP);
          end else begin
            amt_r <= nq[47:0];
          end
        end
      end
      cfk_pkg::ST_FS: begin
        if (step_done) amt_r <= (fs > FS_CAP) ? 48'(FS_CAP) : fs[47:0];
      end
      cfk_pkg::ST_SQ: begin
        if (step_done) sq_r <= axis_r ? sq_r + alu_res : alu_res;
      end
      cfk_pkg::ST_ROOT:  if (step_done) len_r <= alu_res[31:0];
      cfk_pkg::ST_SCALE: if (step_done) tmp_r <= alu_res;
      cfk_pkg::ST_QM: begin
        if (step_done) begin
          if (axis_r) begin
            ay_r <= cfk_pkg::sat32(base_s + q_s);
          end else begin
            ax_r <= cfk_pkg::sat32(base_s + q_s);
          end
        end
      end
      cfk_pkg::ST_DT2: if (step_done) dt2_r <= alu_res[31:0];
      cfk_pkg::ST_PV: begin
        if (step_done) dp_r <= vel_cur[31] ? -$signed(36'(r_v)) : $signed(36'(r_v));
      end
      cfk_pkg::ST_PA: begin
        if (step_done) begin
          dp_r <= dp_r + (acc_cur[31] ? -$signed(36'(r_a)) : $signed(36'(r_a)));
        end
      end
      cfk_pkg::ST_OUT: begin
        if (out_free) begin
          out_data_r <= {7'd0, moving_r, vely_r, velx_r, posy_r, posx_r};
        end
      end
      default: begin
        dt_r <= dt_r;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

/* rtl/cfk_serial_alu.sv */
// ----------------------------------------------------------------------------
// cfk_serial_alu: bit-serial multiply, divide and square root
// Shift-add multiply (32 steps), restoring divide (64 steps) and
// digit-by-digit square root (32 steps), one bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfk_serial_alu (
  input  logic             clk,
  input  logic             rst_n,
  input  cfk_pkg::alu_req_t req,
  input  logic [63:0]      a_i,     // multiplicand, dividend or radicand
  input  logic [31:0]      b_i,     // multiplier or divisor
  output logic [63:0]      result,
  output cfk_pkg::alu_sts_t sts
);

  localparam logic [5:0] LAST_MUL  = 6'd31;
  localparam logic [5:0] LAST_DIV  = 6'd63;
  localparam logic [5:0] LAST_SQRT = 6'd31;

  cfk_pkg::alu_op_t op_r;
  logic        busy_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic [5:0]  last;
  logic [63:0] acc_r;
  logic [63:0] sh_r;
  logic [31:0] mb_r;
  logic [35:0] rem_r;
  logic [31:0] root_r;

  logic [35:0] div_sh;
  logic [35:0] sq_sh;
  logic [35:0] sq_trial;

  // Pick the step count of the running operation
  always_comb begin
    case (op_r)
      cfk_pkg::ALU_MUL:  last = LAST_MUL;
      cfk_pkg::ALU_DIV:  last = LAST_DIV;
      cfk_pkg::ALU_SQRT: last = LAST_SQRT;
      default:           last = LAST_MUL;
    endcase
  end

  assign div_sh   = {rem_r[34:0], sh_r[63]};
  assign sq_sh    = {rem_r[33:0], sh_r[63:62]};
  assign sq_trial = {2'b00, root_r, 2'b01};

  // Sequence the steps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
      op_r   <= cfk_pkg::ALU_MUL;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd0;
        op_r   <= req.op;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Advance one bit of the running operation
  always_ff @(posedge clk) begin
    if (req.start && !busy_r) begin
      acc_r  <= 64'd0;
      sh_r   <= a_i;
      mb_r   <= b_i;
      rem_r  <= 36'd0;
      root_r <= 32'd0;
    end else if (busy_r) begin
      case (op_r)
        cfk_pkg::ALU_MUL: begin
          if (mb_r[0]) begin
            acc_r <= acc_r + sh_r;
          end
          sh_r <= {sh_r[62:0], 1'b0};
          mb_r <= {1'b0, mb_r[31:1]};
        end
        cfk_pkg::ALU_DIV: begin
          if (div_sh >= {4'd0, mb_r}) begin
            rem_r <= div_sh - {4'd0, mb_r};
            sh_r  <= {sh_r[62:0], 1'b1};
          end else begin
            rem_r <= div_sh;
            sh_r  <= {sh_r[62:0], 1'b0};
          end
        end
        cfk_pkg::ALU_SQRT: begin
          if (sq_sh >= sq_trial) begin
            rem_r  <= sq_sh - sq_trial;
            root_r <= {root_r[30:0], 1'b1};
          end else begin
            rem_r  <= sq_sh;
            root_r <= {root_r[30:0], 1'b0};
          end
          sh_r <= {sh_r[61:0], 2'b00};
        end
        default: begin
          acc_r <= acc_r;
        end
      endcase
    end
  end

  // Drive the result of the finished operation
  always_comb begin
    case (op_r)
      cfk_pkg::ALU_MUL:  result = acc_r;
      cfk_pkg::ALU_DIV:  result = sh_r;
      cfk_pkg::ALU_SQRT: result = {32'd0, root_r};
      default:           result = acc_r;
    endcase
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;

`ifndef SYNTHESIS
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !(req.start && busy_r))
    else $error("alu started while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && $past(busy_r))
    else $error("alu done without a finished run");
  a_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy_r) |-> $past(req.start))
    else $error("alu busy without start");
`endif

endmodule

/* tb/sv/tb_coulomb_friction_kinematic_step.sv */
// ----------------------------------------------------------------------------
// tb_coulomb_friction_kinematic_step: self-checking bench for the point mass
// Drives force and tick words with random gaps and predicts each result word
// with a local fixed-point model of the friction step or takes it from a
// directed row; compares field by field over register settings, extremes too.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_coulomb_friction_kinematic_step;

  typedef longint unsigned u64;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic               mv;
  } motion_t;

  typedef struct {
    logic               func;
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic [15:0]        dt;
    logic               fr;
    bit                 typed;
    motion_t            want;
  } row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [87:0]  in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [135:0] out_tdata;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_index = '0;
  logic [31:0]  cfg_wdata = '0;

  coulomb_friction_kinematic_step DUT (.*);

  // Body model state and registers
  longint    acc_fx, acc_fy, pos_x, pos_y, vel_x, vel_y;
  bit        forces_seen;
  u64        mass_r, grav_r, mus_r, muk_r;
  longint    base_x, base_y;

  motion_t   pending_motion[$];
  row_t      stim_rows[$];
  int        errors = 0;
  longint    cycles = 0;
  bit        no_idle = 0;
  int        long_hold = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  // Count cycles and stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 4000000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic longint sat(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic u64 magn(input longint v);
    return v < 0 ? u64'(-v) : u64'(v);
  endfunction

  function automatic longint scale_sh(input longint a, input u64 b, input int sh);
    u64 r;
    r = (magn(a) * b) >> sh;
    return a < 0 ? -longint'(r) : longint'(r);
  endfunction

  function automatic u64 root(input u64 v);
    u64 r, b;
    r = 0;
    b = u64'(1) << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Shorten a vector by amt without flipping component signs
  function automatic void shorten(inout longint x, inout longint y, input u64 amt,
                                  input u64 len);
    longint dx, dy;
    dx = longint'((magn(x) * amt) / len);
    dy = longint'((magn(y) * amt) / len);
    x = x > 0 ? x - dx : x + dx;
    y = y > 0 ? y - dy : y + dy;
  endfunction

  function automatic longint per_mass(input longint f);
    u64 q;
    if (f == 0) return 0;
    q = (mass_r == 0) ? (u64'(1) << 40) : (magn(f) << 16) / mass_r;
    return f < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic void add_force(input logic signed [31:0] fx,
                                    input logic signed [31:0] fy);
    acc_fx = sat(acc_fx + longint'(fx));
    acc_fy = sat(acc_fy + longint'(fy));
    forces_seen = 1;
  endfunction

  // Append one stimulus row to the directed table
  function automatic void add_row(input logic func, input logic signed [31:0] fx,
                                  input logic signed [31:0] fy, input logic [15:0] dt,
                                  input logic fr, input bit typed, input motion_t want);
    row_t r;
    r.func  = func;
    r.fx    = fx;
    r.fy    = fy;
    r.dt    = dt;
    r.fr    = fr;
    r.typed = typed;
    r.want  = want;
    stim_rows.insert(stim_rows.size(), r);
  endfunction

  // Advance the body by one tick and return the result word
  function automatic motion_t step_body(input logic [15:0] dt_in, input logic fr);
    longint fx, fy, ax, ay;
    u64 dt, dt2, ak, dv, vsq, nq, fs, fsq;
    bit mv;
    motion_t m;
    dt = u64'(dt_in);
    fx = acc_fx;
    fy = acc_fy;
    mv = (vel_x != 0) || (vel_y != 0);
    if (fr) begin
      if (mv) begin
        ak = (grav_r * muk_r) >> 12;
        dv = (ak * dt) >> 16;
        vsq = magn(vel_x) * magn(vel_x) + magn(vel_y) * magn(vel_y);
        if (dv >= (u64'(1) << 32) || dv * dv >= vsq) begin
          vel_x = 0;
          vel_y = 0;
        end else begin
          shorten(vel_x, vel_y, dv, root(vsq));
        end
      end else begin
        nq = (grav_r * mass_r) >> 16;
        if (mus_r == 0) fs = 0;
        else if (nq > (u64'(1) << 44)) fs = u64'(1) << 40;
        else begin
          fs = (nq * mus_r) >> 12;
          if (fs > (u64'(1) << 40)) fs = u64'(1) << 40;
        end
        fsq = magn(fx) * magn(fx) + magn(fy) * magn(fy);
        if (fs >= (u64'(1) << 32) || fsq <= fs * fs) begin
          fx = 0;
          fy = 0;
        end else begin
          shorten(fx, fy, fs, root(fsq));
        end
      end
    end
    ax = sat((forces_seen ? base_x : 0) + per_mass(fx));
    ay = sat((forces_seen ? base_y : 0) + per_mass(fy));
    dt2 = dt * dt;
    pos_x = sat(pos_x + scale_sh(vel_x, dt, 16) + scale_sh(ax, dt2, 33));
    pos_y = sat(pos_y + scale_sh(vel_y, dt, 16) + scale_sh(ay, dt2, 33));
    vel_x = sat(vel_x + scale_sh(ax, dt, 16));
    vel_y = sat(vel_y + scale_sh(ay, dt, 16));
    acc_fx = 0;
    acc_fy = 0;
    forces_seen = 0;
    m.px = pos_x[31:0];
    m.py = pos_y[31:0];
    m.vx = vel_x[31:0];
    m.vy = vel_y[31:0];
    m.mv = mv;
    return m;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // Send one word; called at a clock edge, returns at its acceptance edge
  task automatic send_word(input logic func, input logic signed [31:0] fx,
                           input logic signed [31:0] fy, input logic [15:0] dt,
                           input logic fr, input bit typed, input motion_t want);
    int gap;
    motion_t m;
    gap = no_idle ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {7'd0, fr, dt, fy, fx};
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    if (func == cfk_pkg::FUNC_FORCE) begin
      add_force(fx, fy);
    end else begin
      m = step_body(dt, fr);
      pending_motion.insert(pending_motion.size(), typed ? want : m);
    end
  endtask

  task automatic drain;
    if (in_tvalid) in_tvalid <= 1'b0;
    while (pending_motion.size() != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      cfk_pkg::REG_MASS:    mass_r = u64'(val);
      cfk_pkg::REG_GRAVITY: grav_r = u64'(val);
      cfk_pkg::REG_STATIC:  mus_r  = u64'(val[15:0]);
      cfk_pkg::REG_KINETIC: muk_r  = u64'(val[15:0]);
      cfk_pkg::REG_BASE_X:  base_x = longint'($signed(val));
      cfk_pkg::REG_BASE_Y:  base_y = longint'($signed(val));
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [31:0] m, input logic [31:0] g,
                          input logic [15:0] s, input logic [15:0] k,
                          input logic [31:0] bx, input logic [31:0] by);
    write_reg(cfk_pkg::REG_MASS, m);
    write_reg(cfk_pkg::REG_GRAVITY, g);
    write_reg(cfk_pkg::REG_STATIC, {16'd0, s});
    write_reg(cfk_pkg::REG_KINETIC, {16'd0, k});
    write_reg(cfk_pkg::REG_BASE_X, bx);
    write_reg(cfk_pkg::REG_BASE_Y, by);
  endtask

  function automatic logic [31:0] rand_force();
    logic [31:0] v;
    case ($urandom_range(0, 4))
      0: v = $urandom;
      1: v = $urandom_range(0, 32'h0010_0000);
      2: v = -$urandom_range(0, 32'h0010_0000);
      3: v = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: v = $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] rand_dt();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 255));
      default: return 16'($urandom_range(0, 16'h1000));
    endcase
  endfunction

  // Mostly force bursts closed by a tick, some stray ticks and forces
  task automatic random_items(input int n);
    motion_t none;
    int nf;
    none = '0;
    while (n > 0) begin
      if ($urandom_range(0, 9) < 8) begin
        nf = $urandom_range(0, 3);
        repeat (nf) send_word(cfk_pkg::FUNC_FORCE, rand_force(), rand_force(),
                              16'($urandom), 1'($urandom), 0, none);
        send_word(cfk_pkg::FUNC_TICK, rand_force(), rand_force(), rand_dt(),
                  1'($urandom), 0, none);
        n -= nf + 1;
      end else begin
        send_word(1'($urandom), rand_force(), rand_force(), rand_dt(), 1'($urandom), 0,
                  none);
        n--;
      end
    end
  endtask

  // Accept result words with random stalls and check them in order
  initial begin
    int gap;
    logic [135:0] got;
    motion_t want;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold > 0) begin
        gap = long_hold;
        long_hold = 0;
      end else begin
        gap = no_idle ? 0 : $urandom_range(0, 18);
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(negedge clk); while (!out_tvalid);
      got = out_tdata;
      @(posedge clk);
      if (pending_motion.size() == 0) begin
        report("unexpected word", got[31:0], 32'd0);
      end else begin
        want = pending_motion.pop_front();
        if (got[31:0] !== want.px) report("position_x", got[31:0], want.px);
        if (got[63:32] !== want.py) report("position_y", got[63:32], want.py);
        if (got[95:64] !== want.vx) report("velocity_x", got[95:64], want.vx);
        if (got[127:96] !== want.vy) report("velocity_y", got[127:96], want.vy);
        if (got[128] !== want.mv) report("moving", {31'd0, got[128]}, {31'd0, want.mv});
      end
    end
  end

  // Stimulus
  initial begin
    motion_t zero;
    zero = '0;
    acc_fx = 0; acc_fy = 0; pos_x = 0; pos_y = 0; vel_x = 0; vel_y = 0;
    forces_seen = 0;
    mass_r = cfk_pkg::MASS_RESET; grav_r = cfk_pkg::GRAVITY_RESET;
    mus_r = cfk_pkg::STATIC_RESET; muk_r = cfk_pkg::KINETIC_RESET;
    base_x = 0; base_y = 0;

    // still body: plain tick, static cancel, then break away and slide to rest
    add_row(cfk_pkg::FUNC_TICK, 0, 0, 16'h0000, 1'b0, 1, zero);
    add_row(cfk_pkg::FUNC_TICK, 32'h1234_5678, -1, 16'hFFFF, 1'b0, 1, zero);
    add_row(cfk_pkg::FUNC_FORCE, 32'h0001_0000, -32'h0001_0000, 16'hFFFF, 1'b1, 0, zero);
    add_row(cfk_pkg::FUNC_TICK, 0, 0, 16'hFFFF, 1'b1, 1, zero);
    add_row(cfk_pkg::FUNC_FORCE, 32'h0010_0000, 32'h0008_0000, 0, 0, 0, zero);
    add_row(cfk_pkg::FUNC_TICK, 0, 0, 16'h8000, 1'b1, 0, zero);
    add_row(cfk_pkg::FUNC_TICK, 0, 0, 16'h4000, 1'b1, 0, zero);
    add_row(cfk_pkg::FUNC_TICK, 0, 0, 16'hFFFF, 1'b1, 0, zero);
    add_row(cfk_pkg::FUNC_TICK, 0, 0, 16'hFFFF, 1'b1, 0, zero);
    add_row(cfk_pkg::FUNC_TICK, 0, 0, 16'h0001, 1'b0, 0, zero);
    // force accumulation saturates both ways
    add_row(cfk_pkg::FUNC_FORCE, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, zero);
    add_row(cfk_pkg::FUNC_FORCE, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, zero);
    add_row(cfk_pkg::FUNC_TICK, 0, 0, 16'hFFFF, 1'b0, 0, zero);
    add_row(cfk_pkg::FUNC_FORCE, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, 1'b1, 0, zero);
    add_row(cfk_pkg::FUNC_FORCE, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, zero);
    add_row(cfk_pkg::FUNC_TICK, 0, 0, 16'hFFFF, 1'b1, 0, zero);
    add_row(cfk_pkg::FUNC_TICK, 0, 0, 16'hFFFF, 1'b0, 0, zero);
    add_row(cfk_pkg::FUNC_TICK, 0, 0, 16'hFFFF, 1'b1, 0, zero);
    add_row(cfk_pkg::FUNC_FORCE, -32'h0003_0000, 32'h0000_0001, 0, 0, 0, zero);
    add_row(cfk_pkg::FUNC_TICK, 0, 0, 16'h0100, 1'b1, 0, zero);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_rows[i])
      send_word(stim_rows[i].func, stim_rows[i].fx, stim_rows[i].fy, stim_rows[i].dt,
                stim_rows[i].fr, stim_rows[i].typed, stim_rows[i].want);
    drain();

    // one phase per register setting; out-of-range indexes must be ignored
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_regs(32'h0000_0001, 32'h0000_0000, 16'h0000, 16'h0000, 32'h7FFF_FFFF,
                    32'h8000_0000);
        1: set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'h8000_0000,
                    32'h7FFF_FFFF);
        2: set_regs(32'h0000_0000, cfk_pkg::GRAVITY_RESET, cfk_pkg::STATIC_RESET,
                    cfk_pkg::KINETIC_RESET, 32'h0000_8000, -32'h0001_0000);
        3: set_regs(32'h0004_0000, 32'h0009_CCCD, 16'h1000, 16'h0800, 0, 0);
        4: set_regs(32'h0000_4000, 32'h0100_0000, 16'hFFFF, 16'h0001, 32'h0002_0000, 0);
        5: set_regs(cfk_pkg::MASS_RESET, cfk_pkg::GRAVITY_RESET, cfk_pkg::STATIC_RESET,
                    cfk_pkg::KINETIC_RESET, 0, 0);
        6: set_regs(32'($urandom), 32'($urandom_range(0, 32'h0100_0000)), 16'($urandom),
                    16'($urandom), 32'($urandom), 32'($urandom));
        default: begin
          set_regs(cfk_pkg::MASS_RESET, cfk_pkg::GRAVITY_RESET, cfk_pkg::STATIC_RESET,
                   cfk_pkg::KINETIC_RESET, 0, 0);
          write_reg(3'd6, 32'hDEAD_BEEF);
          write_reg(3'd7, 32'h0000_0000);
        end
      endcase
      no_idle = (ph == 3);
      if (ph == 1) long_hold = 2000;
      random_items(70);
      if (ph == 4) drain();
      random_items(70);
      drain();
    end
    no_idle = 0;

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/cfk_pkg.sv
rtl/cfk_serial_alu.sv
rtl/coulomb_friction_kinematic_step.sv
tb/sv/tb_coulomb_friction_kinematic_step.sv
